>>> hdl/stream_pattern_censor_top_assert.svh
// Assertion macros for the pattern censor checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef STREAM_PATTERN_CENSOR_TOP_ASSERT_SVH
`define STREAM_PATTERN_CENSOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/spc_pkg.sv
// Shared constants and types for the stream pattern censor.
// No dependencies.
package spc_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int BYTE_W      = 8;
	localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
	localparam int LEN_W       = 4;
	localparam int PAT_W       = MAX_PATTERN * BYTE_W;
	localparam int CFG_W       = 64;
	localparam int CFG_ADDR_W  = 1;

	localparam logic [BYTE_W-1:0] MASK_BYTE = 8'd42;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_PATTERN_LEN   = 1'b0,
		CFG_PATTERN_BYTES = 1'b1
	} cfg_addr_t;

	typedef logic [BYTE_W-1:0] byte_t;

	// Words produced by one input word; entry 0 goes out first.
	typedef struct packed {
		byte_t [MAX_PATTERN-1:0] bytes;
		logic  [CNT_W-1:0]       cnt;
		logic                    last;
	} burst_t;

endpackage

>>> hdl/spc_window.sv
// Config registers, sliding window and match logic of the pattern censor.
// Depends on spc_pkg.
module spc_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [spc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [spc_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         in_take,
	input  spc_pkg::byte_t               in_byte,
	input  logic                         in_last,
	output spc_pkg::burst_t              burst
);
	import spc_pkg::*;

	logic [LEN_W-1:0]        len_q;
	logic [PAT_W-1:0]        pat_q;
	logic [CNT_W-1:0]        fill_q;
	byte_t [MAX_PATTERN-1:0] win_q;

	logic [CNT_W-1:0]        eff_len;
	logic [CNT_W-1:0]        f0;
	logic [CNT_W-1:0]        f1;
	logic [CNT_W-1:0]        fill_n;
	byte_t [MAX_PATTERN-1:0] win_w;
	byte_t [MAX_PATTERN-1:0] win_s;
	logic [MAX_PATTERN-1:0]  hit;
	logic                    full;
	logic                    match;
	logic                    masked;
	logic                    len_wr;

	// 0 acts as 1, anything above the window depth acts as the depth
	always_comb begin
		if (len_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (len_q > LEN_W'(MAX_PATTERN)) begin
			eff_len = CNT_W'(MAX_PATTERN);
		end else begin
			eff_len = CNT_W'(len_q);
		end
	end

	assign f0 = (fill_q >= eff_len) ? '0 : fill_q;
	assign f1 = f0 + CNT_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_w[i] = (CNT_W'(i) == f0) ? in_byte : win_q[i];
			hit[i]   = (win_w[i] == pat_q[i*BYTE_W +: BYTE_W]) || (CNT_W'(i) >= eff_len);
		end
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			win_s[i] = win_w[i+1];
		end
		win_s[MAX_PATTERN-1] = win_w[MAX_PATTERN-1];
	end

	assign match  = &hit;
	assign full   = (f1 == eff_len);
	assign masked = full && match;

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			burst.bytes[i] = masked ? MASK_BYTE : win_w[i];
		end
		// last flushes everything held: f1 words, masked or not
		if (in_last) begin
			burst.cnt = f1;
		end else if (full) begin
			burst.cnt = match ? eff_len : CNT_W'(1);
		end else begin
			burst.cnt = '0;
		end
		burst.last = in_last;
	end

	always_comb begin
		if (in_last || masked) begin
			fill_n = '0;
		end else if (full) begin
			fill_n = eff_len - CNT_W'(1);
		end else begin
			fill_n = f1;
		end
	end

	// a length write empties the window; a pattern write leaves it alone
	assign len_wr = cfg_we && (cfg_addr == CFG_PATTERN_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(1);
			pat_q  <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_PATTERN_LEN: begin
						len_q <= cfg_wdata[LEN_W-1:0];
					end
					CFG_PATTERN_BYTES: begin
						pat_q <= cfg_wdata[PAT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (len_wr) begin
				fill_q <= '0;
			end else if (in_take) begin
				fill_q <= fill_n;
			end
		end
	end

	// window contents only read below fill_q
	always_ff @(posedge clk) begin
		if (in_take) begin
			win_q <= full ? win_s : win_w;
		end
	end

endmodule

>>> hdl/stream_pattern_censor_top.sv
// Top level of the stream pattern censor: input handshake, burst staging, output shifter.
// Depends on spc_pkg and spc_window.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata[7:0] in_byte, s_tlast in_last
//   m_*       out  m_tvalid/m_tready  m_tdata[7:0] out_byte, m_tlast out_last
//   cfg_*     in   cfg_we             cfg_addr index, cfg_wdata value
//
// One input word per cycle when each word yields at most one output word and m_tready stays high.
// A match emits pattern_len asterisks and a last word flushes the window,
// so those hold the input back while their words drain from the output shifter.
// Input reaches the output through the burst stage and then the output shifter.
// arst_n resets config (length 1, pattern zero), window fill and both valid flags; no clearing pass.
// Output stalls back up through the output shifter and then the burst stage.
module stream_pattern_censor_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] in_byte
	input  logic                           s_tlast,   // in_last
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] out_byte
	output logic                           m_tlast,   // out_last
	// config write port
	input  logic                           cfg_we,
	input  logic [spc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [spc_pkg::CFG_W-1:0]      cfg_wdata
);
	import spc_pkg::*;

	logic   in_take;
	burst_t burst;

	// stage 1: burst produced by the last accepted word
	logic   p_valid_s1;
	burst_t p_burst_s1;
	logic   p_move;

	// stage 2: output shifter, entry 0 on the port
	byte_t [MAX_PATTERN-1:0] b_bytes_s2;
	logic  [CNT_W-1:0]       b_cnt_s2;
	logic                    b_last_s2;
	logic                    b_take;
	logic                    b_free;

	spc_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_take   (in_take),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.burst     (burst)
	);

	// shifter can take a new burst once its final word leaves
	assign b_take   = m_tvalid && m_tready;
	assign b_free   = (b_cnt_s2 == '0) || ((b_cnt_s2 == CNT_W'(1)) && m_tready);
	assign p_move   = p_valid_s1 && b_free;

	assign s_tready = !p_valid_s1 || p_move;
	assign in_take  = s_tvalid && s_tready;

	assign m_tvalid = (b_cnt_s2 != '0);
	assign m_tdata  = b_bytes_s2[0];
	assign m_tlast  = b_last_s2 && (b_cnt_s2 == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_valid_s1 <= 1'b0;
			b_cnt_s2   <= '0;
		end else begin
			// words that produce nothing never occupy the stage
			if (in_take) begin
				p_valid_s1 <= (burst.cnt != '0);
			end else if (p_move) begin
				p_valid_s1 <= 1'b0;
			end
			if (p_move) begin
				b_cnt_s2 <= p_burst_s1.cnt;
			end else if (b_take) begin
				b_cnt_s2 <= b_cnt_s2 - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			p_burst_s1 <= burst;
		end
		if (p_move) begin
			b_bytes_s2 <= p_burst_s1.bytes;
			b_last_s2  <= p_burst_s1.last;
		end else if (b_take) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				b_bytes_s2[i] <= b_bytes_s2[i+1];
			end
		end
	end

endmodule

>>> hdl/spc_checker.sv
// Port-level checks for the stream pattern censor, bound to the top level.
// Depends on stream_pattern_censor_top_assert.svh.
`include "stream_pattern_censor_top_assert.svh"

module spc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// a stalled output word holds
	`SPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

	// with nothing on the output the input side never stalls
	`SPC_ASSERT_NOW(a_idle_ready, !m_tvalid, s_tready, "input stalled while output empty")

	// a last input must show up as output once past the burst stage and output shifter registers
	`SPC_ASSERT_NOW(a_last_out, s_tvalid && s_tready && s_tlast, ##2 m_tvalid, "no output after last input word")

endmodule

bind stream_pattern_censor_top spc_checker u_spc_checker (.*);
